>>> src/fixed_slot_free_list_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Free list allocator assertion macros
// Shared concurrent assertion forms for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FSLA_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("allocator check failed");

// next-cycle implication
`define FSLA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("allocator check failed");

`endif

>>> src/fsla_pkg.sv
// ----------------------------------------------------------------------------
// Free list allocator package
// Sizes, codes and shared types of the fixed slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fsla_pkg;

  localparam int MAX_SLOTS      = 1024;
  localparam int MIN_SLOT_BYTES = 4;
  localparam int IDX_W          = $clog2(MAX_SLOTS);
  localparam int CNT_W          = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W         = 32;
  localparam int SIZE_W         = 16;
  localparam int SPAN_W         = CNT_W + SIZE_W;
  localparam int LIVE_W         = 11;
  localparam int DIV_CNT_W      = $clog2(ADDR_W);

  localparam logic [CNT_W-1:0]  LINK_END  = CNT_W'(MAX_SLOTS);
  localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(MAX_SLOTS);
  localparam logic [SIZE_W-1:0] SIZE_MIN  = SIZE_W'(MIN_SLOT_BYTES);
  localparam logic [LIVE_W-1:0] LIVE_MAX  = '1;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FOREIGN   = 2'd2,
    ST_NULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_BASE       = 2'd0,
    CFG_SLOT_BYTES = 2'd1,
    CFG_SLOTS      = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_ADDR,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [SIZE_W-1:0] slot_bytes;
    logic [CNT_W-1:0]  slots_in_use;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] slot_address;
    logic              owned;
    logic [CNT_W-1:0]  available;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> src/fsla_div.sv
// ----------------------------------------------------------------------------
// Free list allocator divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fsla_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [fsla_pkg::ADDR_W-1:0] dividend,
  input  wire logic [fsla_pkg::SIZE_W-1:0] divisor,
  output fsla_pkg::div_stat_t             stat,
  output logic [fsla_pkg::ADDR_W-1:0]     quotient,
  output logic [fsla_pkg::SIZE_W-1:0]     remainder
);
  import fsla_pkg::*;

  logic [ADDR_W-1:0]    dvd;
  logic [SIZE_W-1:0]    dsr;
  logic [SIZE_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [SIZE_W:0]      trial;
  logic                 fits;

  always_comb begin
    trial = {rem, dvd[ADDR_W-1]};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[ADDR_W-2:0], fits};
      rem <= fits ? SIZE_W'(trial - {1'b0, dsr}) : trial[SIZE_W-1:0];
    end
  end

  assign stat      = '{busy: busy, done: done};
  assign quotient  = dvd;
  assign remainder = rem;

endmodule

`default_nettype wire

>>> src/fsla_core.sv
// ----------------------------------------------------------------------------
// Free list allocator core
// Sequencer, free list state, link memory and the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module fsla_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fsla_pkg::cfg_t              cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_op,
  input  wire logic [fsla_pkg::ADDR_W-1:0] in_addr,
  input  wire logic                        out_free,
  output logic                             res_load,
  output fsla_pkg::res_t                   res
);
  import fsla_pkg::*;

  state_t state;
  state_t state_next;

  op_t               op;
  logic [ADDR_W-1:0] addr;

  logic [IDX_W-1:0]  head;
  logic              head_valid;
  logic [CNT_W-1:0]  fresh;
  logic [LIVE_W-1:0] live;

  logic [IDX_W-1:0]  acq_idx;
  logic              acq_got;
  logic              acq_from_head;

  logic [SPAN_W-1:0] prod;
  logic [ADDR_W-1:0] off;
  logic              below_base;

  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;
  logic              res_owned;

  logic [CNT_W-1:0]  link_mem [MAX_SLOTS];
  logic [CNT_W-1:0]  link_rd;

  logic [SIZE_W-1:0] size_eff;
  logic [CNT_W-1:0]  count_eff;
  logic [CNT_W-1:0]  mul_a;
  logic [CNT_W-1:0]  avail;
  logic              in_range;
  logic              null_rel;
  logic              div_start;
  logic              div_hit;
  logic              mem_we;

  div_stat_t         dstat;
  logic [ADDR_W-1:0] quot;
  logic [SIZE_W-1:0] rem;

  fsla_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (off),
    .divisor   (size_eff),
    .stat      (dstat),
    .quotient  (quot),
    .remainder (rem)
  );

  always_comb begin
    size_eff  = (cfg.slot_bytes < SIZE_MIN) ? SIZE_MIN : cfg.slot_bytes;
    count_eff = (cfg.slots_in_use > COUNT_MAX) ? COUNT_MAX : cfg.slots_in_use;
    mul_a     = (op == OP_ACQUIRE) ? CNT_W'(acq_idx) : count_eff;
    avail     = (CNT_W'(live) >= count_eff) ? '0 : CNT_W'(count_eff - CNT_W'(live));
    in_range  = !below_base && (off < ADDR_W'(prod));
    null_rel  = (op == OP_RELEASE) && (addr == '0);
    div_hit   = (rem == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_PREP;
      S_PREP:  state_next = (op == OP_INIT) ? S_DONE : S_MUL;
      S_MUL:   state_next = (op == OP_ACQUIRE) ? S_ADDR : S_CHECK;
      S_ADDR:  state_next = S_DONE;
      S_CHECK: state_next = (null_rel || !in_range) ? S_DONE : S_DIV;
      S_DIV:   if (dstat.done) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    div_start = (state == S_CHECK) && !null_rel && in_range;
    mem_we    = (state == S_DIV) && dstat.done && (op == OP_RELEASE) && div_hit;
    res_load  = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[quot[IDX_W-1:0]] <= head_valid ? CNT_W'(head) : LINK_END;
    end
    link_rd <= link_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      head_valid <= 1'b0;
      fresh      <= '0;
      live       <= '0;
    end else begin
      if (state == S_PREP && op == OP_INIT) begin
        head       <= '0;
        head_valid <= 1'b0;
        fresh      <= '0;
        live       <= '0;
      end
      if (state == S_MUL && op == OP_ACQUIRE && acq_got) begin
        if (acq_from_head) begin
          if (!link_rd[CNT_W-1]) begin
            head <= link_rd[IDX_W-1:0];
          end else begin
            head_valid <= 1'b0;
          end
        end else begin
          fresh <= fresh + 1'b1;
        end
        if (live != LIVE_MAX) live <= live + 1'b1;
      end
      if (mem_we) begin
        head       <= quot[IDX_W-1:0];
        head_valid <= 1'b1;
        if (live != '0) live <= live - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         <= op_t'(in_op);
          addr       <= in_addr;
          res_status <= ST_OK;
          res_addr   <= '0;
          res_owned  <= 1'b0;
        end
      end
      S_PREP: begin
        acq_from_head <= head_valid;
        if (head_valid) begin
          acq_idx <= head;
          acq_got <= 1'b1;
        end else if (fresh < count_eff) begin
          acq_idx <= fresh[IDX_W-1:0];
          acq_got <= 1'b1;
        end else begin
          acq_idx <= '0;
          acq_got <= 1'b0;
        end
      end
      S_MUL: begin
        prod       <= mul_a * size_eff;
        off        <= addr - cfg.base_address;
        below_base <= addr < cfg.base_address;
        if (op == OP_ACQUIRE && !acq_got) res_status <= ST_EXHAUSTED;
      end
      S_ADDR: begin
        if (acq_got) res_addr <= cfg.base_address + ADDR_W'(prod);
      end
      S_CHECK: begin
        if (null_rel) begin
          res_status <= ST_NULL;
        end else if (!in_range && op == OP_RELEASE) begin
          res_status <= ST_FOREIGN;
        end
      end
      S_DIV: begin
        if (dstat.done) begin
          res_owned <= div_hit;
          if (op == OP_RELEASE && !div_hit) res_status <= ST_FOREIGN;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign res = '{status: res_status, slot_address: res_addr, owned: res_owned,
                 available: avail};

endmodule

`default_nettype wire

>>> src/fixed_slot_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// Fixed slot free list allocator
// Pool of equal slots from a base address: init, acquire, release, query.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request word (operation, address); m_* returns exactly
//   one result word per request (status, slot address, owned, available).
//   cfg_* writes base address (0), slot bytes (1) and slot count (2); write
//   only while no request is in flight. cfg_ready is always high.
//   Steps: init runs prep and done; acquire runs prep, multiply, address
//   and done; release and query run prep, multiply, check and done when
//   rejected by the null or range check, with a divide step otherwise.
//   The slot index comes from a shared restoring divider, one quotient
//   bit per cycle; it sets the pace of release and query.
//   One request is processed at a time; s_tready is high only when idle.
//   The result sits in an output register; a stalled m_tready holds it,
//   and the next request may be taken while it waits.
//   Reset empties the pool (same as init) and loads base 4096, 16 bytes
//   per slot and 1024 slots; the link memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_slot_free_list_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,    // operation[1:0], address[33:2], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,    // status[1:0], slot_address[33:2],
                                       // owned[34], available[45:35], zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import fsla_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_load;
  logic out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= 32'd4096;
      cfg.slot_bytes   <= 16'd16;
      cfg.slots_in_use <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      priority case (cfg_index_t'(cfg_index))
        CFG_BASE:       cfg.base_address <= cfg_data;
        CFG_SLOT_BYTES: cfg.slot_bytes   <= cfg_data[SIZE_W-1:0];
        CFG_SLOTS:      cfg.slots_in_use <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  fsla_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tdata[1:0]),
    .in_addr  (s_tdata[33:2]),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {2'b00, res.available, res.owned, res.slot_address, res.status};
    end
  end

endmodule

`default_nettype wire

>>> src/fsla_chk.sv
// ----------------------------------------------------------------------------
// Free list allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_slot_free_list_allocator_top_defines.svh"

module fsla_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata
);
  import fsla_pkg::*;

  `FSLA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `FSLA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `FSLA_ASSERT_NOW(a_fail_no_addr, m_tvalid && (m_tdata[1:0] != ST_OK),
                   m_tdata[33:2] == 32'd0)
  `FSLA_ASSERT_NOW(a_owned_ok, m_tvalid && m_tdata[34], m_tdata[1:0] == ST_OK)
  `FSLA_ASSERT_NOW(a_avail_range, m_tvalid, m_tdata[45:35] <= COUNT_MAX)

endmodule

bind fixed_slot_free_list_allocator_top fsla_chk u_fsla_chk (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);

`default_nettype wire

>>> bench/tb_fixed_slot_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// Fixed slot free list allocator testbench
// Sends init, acquire, release and query words under changing pool settings
// and idle/stall patterns, predicts every result word from a local copy of
// the pool state and compares each returned word field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fixed_slot_free_list_allocator_top;
  import fsla_pkg::*;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [39:0] s_tdata   = '0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CFG_BASE;
  logic [31:0] cfg_data  = '0;
  wire logic        s_tready;
  wire logic        m_tvalid;
  wire logic [47:0] m_tdata;
  wire logic        cfg_ready;

  fixed_slot_free_list_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int reg_writes     = 0;
  int words_sent     = 0;
  int op_count [4];

  // pool model state
  logic [31:0]      pool_base;
  logic [15:0]      req_bytes;
  logic [10:0]      req_count;
  logic [CNT_W-1:0] link_mem [MAX_SLOTS];
  logic [CNT_W-1:0] head_idx;
  bit               head_ok;
  int unsigned      fresh_idx;
  int unsigned      live_cnt;

  res_t        results_owed [$];
  logic [31:0] held [$];

  initial forever #2 clk = ~clk;

  initial forever begin
    @(negedge clk);
    m_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #(20_000_000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned eff_bytes();
    return (req_bytes < SIZE_MIN) ? MIN_SLOT_BYTES : req_bytes;
  endfunction

  function automatic int unsigned slot_total();
    return (req_count > COUNT_MAX) ? MAX_SLOTS : req_count;
  endfunction

  function automatic int unsigned free_left();
    return (live_cnt >= slot_total()) ? 0 : slot_total() - live_cnt;
  endfunction

  function automatic void pool_clear();
    head_ok   = 1'b0;
    head_idx  = '0;
    fresh_idx = 0;
    live_cnt  = 0;
  endfunction

  function automatic bit slot_of(input logic [31:0] addr, output int unsigned idx);
    logic [63:0] off;
    logic [63:0] span;
    idx = 0;
    if (addr < pool_base) return 1'b0;
    off  = {32'd0, addr - pool_base};
    span = 64'(eff_bytes()) * 64'(slot_total());
    if (off >= span) return 1'b0;
    if (off % eff_bytes() != 0) return 1'b0;
    idx = int'(off / eff_bytes());
    return idx < MAX_SLOTS;
  endfunction

  function automatic res_t pool_step(input op_t op, input logic [31:0] addr);
    res_t        r;
    int unsigned idx;
    bit          got;
    r   = '0;
    idx = 0;
    got = 1'b0;
    case (op)
      OP_INIT: pool_clear();
      OP_ACQUIRE: begin
        if (head_ok) begin
          idx = head_idx;
          if (link_mem[head_idx] < LINK_END) head_idx = link_mem[head_idx];
          else head_ok = 1'b0;
          got = 1'b1;
        end else if (fresh_idx < slot_total()) begin
          idx = fresh_idx;
          fresh_idx++;
          got = 1'b1;
        end
        if (got) begin
          r.slot_address = pool_base + 32'(idx * eff_bytes());
          if (live_cnt < LIVE_MAX) live_cnt++;
        end else begin
          r.status = ST_EXHAUSTED;
        end
      end
      OP_RELEASE: begin
        if (addr == 32'd0) begin
          r.status = ST_NULL;
        end else if (slot_of(addr, idx)) begin
          r.owned       = 1'b1;
          link_mem[idx] = head_ok ? head_idx : LINK_END;
          head_idx      = CNT_W'(idx);
          head_ok       = 1'b1;
          if (live_cnt > 0) live_cnt--;
        end else begin
          r.status = ST_FOREIGN;
        end
      end
      OP_QUERY: r.owned = slot_of(addr, idx);
    endcase
    r.available = CNT_W'(free_left());
    return r;
  endfunction

  task automatic note_mismatch(input string what, input res_t want, input res_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp st %0d addr %h own %0d av %0d, got st %0d addr %h own %0d av %0d",
               $time, what, want.status, want.slot_address, want.owned, want.available,
               seen.status, seen.slot_address, seen.owned, seen.available);
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen.status       = status_t'(m_tdata[1:0]);
      seen.slot_address = m_tdata[33:2];
      seen.owned        = m_tdata[34];
      seen.available    = m_tdata[45:35];
      results_seen++;
      if (results_owed.size() == 0) begin
        note_mismatch("unexpected word", '0, seen);
      end else begin
        want = results_owed.pop_front();
        if (seen.status != want.status || seen.slot_address != want.slot_address ||
            seen.owned != want.owned || seen.available != want.available)
          note_mismatch("result mismatch", want, seen);
      end
    end
  end

  task automatic send_word(input op_t op, input logic [31:0] addr, output res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {6'd0, addr, op};
    do @(posedge clk); while (!s_tready);
    want = pool_step(op, addr);
    results_owed.push_back(want);
    words_sent++;
    op_count[op]++;
    if (op == OP_INIT) held.delete();
    if (op == OP_ACQUIRE && want.status == ST_OK) held.push_back(want.slot_address);
    @(negedge clk);
  endtask

  task automatic send(input op_t op, input logic [31:0] addr);
    res_t want;
    send_word(op, addr, want);
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (results_owed.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t which, input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = which;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (which)
      CFG_BASE:       pool_base = value;
      CFG_SLOT_BYTES: req_bytes = value[15:0];
      CFG_SLOTS:      req_count = value[10:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_pool(input logic [31:0] base, input logic [31:0] bytes,
                          input logic [31:0] count);
    wait_idle();
    write_reg(CFG_BASE, base);
    write_reg(CFG_SLOT_BYTES, bytes);
    write_reg(CFG_SLOTS, count);
  endtask

  task automatic set_traffic(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  function automatic logic [31:0] any_slot();
    if (slot_total() == 0) return $urandom;
    return pool_base + 32'(eff_bytes() * $urandom_range(slot_total() - 1, 0));
  endfunction

  function automatic logic [31:0] stray_addr();
    case ($urandom_range(3))
      0: return pool_base - 32'($urandom_range(64, 1));
      1: return any_slot() + 32'($urandom_range(eff_bytes() - 1, 1));
      2: return pool_base + 32'(eff_bytes() * slot_total());
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_ops();
    set_traffic(0);
    send(OP_QUERY, 32'd4096);
    send(OP_QUERY, 32'd4095);
    send(OP_QUERY, 32'd4096 + 32'd16 * 32'd1024);
    send(OP_QUERY, 32'd4097);
    send(OP_QUERY, 32'd0);
    send(OP_QUERY, 32'hFFFF_FFFF);
    send(OP_RELEASE, 32'd0);
    send(OP_RELEASE, 32'd4100);
    send(OP_RELEASE, 32'd4096 + 32'd16 * 32'd1024);
    repeat (3) send(OP_ACQUIRE, 32'd0);
    send(OP_RELEASE, 32'd4112);
    send(OP_ACQUIRE, 32'd0);
    send(OP_INIT, 32'd0);
    send(OP_RELEASE, 32'd4096);
    send(OP_ACQUIRE, 32'd0);
    send(OP_RELEASE, 32'd4096);
    send(OP_RELEASE, 32'd4096);
    send(OP_ACQUIRE, 32'd0);
    send(OP_ACQUIRE, 32'd0);
    send(OP_INIT, 32'd0);
  endtask

  task automatic test_config_extremes();
    set_traffic(3);
    set_pool(32'd1, 32'd1, 32'd1);
    send(OP_INIT, 32'd0);
    send(OP_ACQUIRE, 32'd0);
    send(OP_ACQUIRE, 32'd0);
    send(OP_QUERY, 32'd1);
    send(OP_QUERY, 32'd5);
    send(OP_RELEASE, 32'd1);
    set_pool(32'h8000_0000, 32'd3, 32'd0);
    send(OP_ACQUIRE, 32'd0);
    send(OP_QUERY, 32'h8000_0000);
    send(OP_RELEASE, 32'h8000_0000);
    // shrink the pool while released slots are still listed
    set_pool(32'd4096, 32'd16, 32'd1024);
    send(OP_INIT, 32'd0);
    repeat (4) send(OP_ACQUIRE, 32'd0);
    for (int i = 0; i < 4; i++) send(OP_RELEASE, 32'd4096 + 32'(16 * i));
    set_pool(32'd4096, 32'd16, 32'd2);
    repeat (5) send(OP_ACQUIRE, 32'd0);
    send(OP_QUERY, 32'd4096 + 32'd48);
    set_pool(32'hFFFF_FFFF, 32'd65535, 32'd1024);
    send(OP_INIT, 32'd0);
    repeat (3) send(OP_ACQUIRE, 32'd0);
    send(OP_RELEASE, 32'hFFFF_FFFF + 32'd65535);
    send(OP_QUERY, 32'hFFFF_FFFF);
    send(OP_RELEASE, 32'hFFFF_FFFF);
    set_pool(32'd4096, 32'd8, 32'd2047);
    send(OP_QUERY, 32'd4096 + 32'd8 * 32'd1023);
    send(OP_QUERY, 32'd4096 + 32'd8 * 32'd1024);
    send(OP_ACQUIRE, 32'd0);
  endtask

  task automatic test_live_saturation();
    set_traffic(0);
    set_pool(32'd4096, 32'd16, 32'd8);
    send(OP_INIT, 32'd0);
    // a slot released twice links to itself and is handed out forever
    send(OP_RELEASE, 32'd4096);
    send(OP_RELEASE, 32'd4096);
    repeat (60) send(OP_ACQUIRE, 32'd0);
    send(OP_INIT, 32'd0);
  endtask

  task automatic test_random_traffic();
    int          roll;
    int          pick;
    logic [31:0] addr;
    res_t        want;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_pool(32'd4096, 32'd16, 32'd1024);
        1: set_pool(32'd1, 32'd1, 32'd1);
        2: set_pool($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(64, 1),
                    $urandom_range(40, 2));
        3: set_pool(32'hFFFF_F000, 32'd16, 32'd256);
        4: set_pool($urandom_range(32'hFFFF, 1), 32'd65535, 32'd1024);
        5: set_pool($urandom_range(32'hFFFF_FFFF, 1), 32'd3, 32'd2047);
        6: set_pool($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(200, 4),
                    $urandom_range(8, 0));
        default: set_pool(32'd4096, 32'd16, 32'd1024);
      endcase
      set_traffic(phase % 4);
      if (phase == 0 || $urandom_range(1)) send(OP_INIT, 32'd0);
      repeat (216) begin
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        if (roll < 3) begin
          send_word(OP_INIT, $urandom, want);
        end else if (roll < 40) begin
          send_word(OP_ACQUIRE, $urandom, want);
        end else if (roll < 75) begin
          if (pick < 70 && held.size() != 0) begin
            roll = $urandom_range(held.size() - 1);
            addr = held[roll];
            held.delete(roll);
          end else if (pick < 80) addr = any_slot();
          else if (pick < 87) addr = 32'd0;
          else addr = stray_addr();
          send_word(OP_RELEASE, addr, want);
        end else begin
          if (pick < 40) addr = any_slot();
          else if (pick < 55 && held.size() != 0) addr = held[$urandom_range(held.size() - 1)];
          else if (pick < 85) addr = stray_addr();
          else addr = $urandom;
          send_word(OP_QUERY, addr, want);
        end
      end
    end
  endtask

  initial begin
    pool_base = 32'd4096;
    req_bytes = 16'd16;
    req_count = 11'd1024;
    pool_clear();
    foreach (op_count[i]) op_count[i] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_ops();
    test_config_extremes();
    test_live_saturation();
    test_random_traffic();

    wait_idle();
    repeat (48) @(posedge clk);
    $display("Sent %0d words (%0d init, %0d acquire, %0d release, %0d query), %0d register writes",
             words_sent, op_count[OP_INIT], op_count[OP_ACQUIRE], op_count[OP_RELEASE],
             op_count[OP_QUERY], reg_writes);
    $display("Checked %0d result words, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
